### src/pclo_pkg.sv
package pclo_pkg;

  // Fixed field widths.
  localparam int VEC_W    = 63;
  localparam int COMP_W   = 21;
  localparam int FRAC_W   = 24;
  localparam int WRAP_W   = 16;
  localparam int RAD_W    = 20;
  localparam int R2_W     = 2 * RAD_W;
  localparam int DIVREG_W = 5;
  localparam int CFGIDX_W = 3;
  localparam int DIFF_W   = COMP_W + 1;
  localparam int IMG_W    = COMP_W + 2;
  localparam int X_W      = COMP_W + 3;
  localparam int SQ_W     = 2 * X_W - 1;
  localparam int SUM_W    = SQ_W + 2;

  // Operation codes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // Status codes.
  localparam logic STAT_OK      = 1'b0;
  localparam logic STAT_DROPPED = 1'b1;

  // Register indexes.
  localparam logic [CFGIDX_W-1:0] REG_VEC_A  = 3'd0;
  localparam logic [CFGIDX_W-1:0] REG_VEC_B  = 3'd1;
  localparam logic [CFGIDX_W-1:0] REG_VEC_C  = 3'd2;
  localparam logic [CFGIDX_W-1:0] REG_RADIUS = 3'd3;
  localparam logic [CFGIDX_W-1:0] REG_DIV_A  = 3'd4;
  localparam logic [CFGIDX_W-1:0] REG_DIV_B  = 3'd5;
  localparam logic [CFGIDX_W-1:0] REG_DIV_C  = 3'd6;

  // Neighbor and image offset codes along one axis.
  localparam logic [1:0] OFS_NEG  = 2'd0;
  localparam logic [1:0] OFS_ZERO = 2'd1;
  localparam logic [1:0] OFS_POS  = 2'd2;

  typedef struct packed {
    logic [1:0] ia;
    logic [1:0] ib;
    logic [1:0] ic;
  } ofs_sel_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] x;
    logic signed [DIFF_W-1:0] y;
    logic signed [DIFF_W-1:0] z;
  } diff_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_HASH, ST_NB, ST_IDX1, ST_IDX2, ST_FRD, ST_FUSE,
    ST_PRD, ST_PUSE, ST_IMG, ST_SQ, ST_CMP, ST_DONE
  } state_t;

  // One box vector scaled by -1, 0 or +1.
  function automatic logic signed [IMG_W-1:0] ofs_term(
      input logic [1:0] sel, input logic signed [COMP_W-1:0] v);
    logic signed [IMG_W-1:0] r;
    case (sel)
      OFS_NEG: r = -IMG_W'(v);
      OFS_POS: r = IMG_W'(v);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Odometer step over the 27 offset combinations, last axis fastest.
  function automatic ofs_sel_t ofs_next(input ofs_sel_t s);
    ofs_sel_t r;
    r = s;
    if (s.ic != OFS_POS) begin
      r.ic = s.ic + 2'd1;
    end else begin
      r.ic = OFS_NEG;
      if (s.ib != OFS_POS) begin
        r.ib = s.ib + 2'd1;
      end else begin
        r.ib = OFS_NEG;
        r.ia = s.ia + 2'd1;
      end
    end
    return r;
  endfunction

  function automatic logic ofs_last(input ofs_sel_t s);
    return (s.ia == OFS_POS) && (s.ib == OFS_POS) && (s.ic == OFS_POS);
  endfunction

endpackage

### src/pclo_fill_ram.sv
module pclo_fill_ram #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/pclo_point_ram.sv
module pclo_point_ram #(
  parameter int ADDR_W = 15
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [ADDR_W-1:0]         waddr,
  input  logic [pclo_pkg::VEC_W-1:0] wdata,
  input  logic                      re,
  input  logic [ADDR_W-1:0]         raddr,
  output logic [pclo_pkg::VEC_W-1:0] rdata
);
  import pclo_pkg::*;

  logic [VEC_W-1:0] mem [2**ADDR_W];

  // Stored positions, packed z, y, x; registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/pclo_dist.sv
module pclo_dist (
  input  logic                       clk,
  input  logic [pclo_pkg::VEC_W-1:0] vec_a,
  input  logic [pclo_pkg::VEC_W-1:0] vec_b,
  input  logic [pclo_pkg::VEC_W-1:0] vec_c,
  input  pclo_pkg::diff_t            diff,
  input  pclo_pkg::ofs_sel_t         sel,
  input  logic [pclo_pkg::R2_W-1:0]  r2,
  output logic                       hit
);
  import pclo_pkg::*;

  logic signed [IMG_W-1:0] img_x, img_y, img_z;
  logic signed [X_W-1:0]   x, y, z;
  logic signed [2*X_W-1:0] px, py, pz;
  logic [SQ_W-1:0]         sq_x, sq_y, sq_z;
  logic [SUM_W-1:0]        sum;

  // Box image offset for the selected combination of vectors.
  always_comb begin
    img_x = ofs_term(sel.ia, signed'(vec_a[COMP_W-1:0]))
          + ofs_term(sel.ib, signed'(vec_b[COMP_W-1:0]))
          + ofs_term(sel.ic, signed'(vec_c[COMP_W-1:0]));
    img_y = ofs_term(sel.ia, signed'(vec_a[2*COMP_W-1:COMP_W]))
          + ofs_term(sel.ib, signed'(vec_b[2*COMP_W-1:COMP_W]))
          + ofs_term(sel.ic, signed'(vec_c[2*COMP_W-1:COMP_W]));
    img_z = ofs_term(sel.ia, signed'(vec_a[3*COMP_W-1:2*COMP_W]))
          + ofs_term(sel.ib, signed'(vec_b[3*COMP_W-1:2*COMP_W]))
          + ofs_term(sel.ic, signed'(vec_c[3*COMP_W-1:2*COMP_W]));
  end

  // First stage: displacement to the image.
  always_ff @(posedge clk) begin
    x <= X_W'(diff.x) - X_W'(img_x);
    y <= X_W'(diff.y) - X_W'(img_y);
    z <= X_W'(diff.z) - X_W'(img_z);
  end

  assign px = x * x;
  assign py = y * y;
  assign pz = z * z;

  // Second stage: squares per axis.
  always_ff @(posedge clk) begin
    sq_x <= px[SQ_W-1:0];
    sq_y <= py[SQ_W-1:0];
    sq_z <= pz[SQ_W-1:0];
  end

  // Squared distance against squared radius.
  assign sum = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
  assign hit = sum < SUM_W'(r2);

endmodule

### src/periodic_cell_list_occupancy_core.sv
// Periodic cell-list occupancy core.
// Items arrive on the input channel (in_valid/in_ready) with an operation,
// three fractional coordinates and a Cartesian position. An insert files the
// position into its grid bucket; a query asks whether any stored point lies
// strictly inside the configured radius under the minimum image. Every item
// gives one result word (occupied, status) on the output channel
// (out_valid/out_ready). One item is processed at a time. An insert hashes
// its bucket, reads its fill count and, unless the bucket is full, stores
// the point; the core is ready for the next word once the result is loaded.
// A query walks the 27 neighboring buckets through the fill memory and the
// point memory, and tests each stored point against the 27 box images in the
// distance unit; it ends at the first match. The result sits in an output
// register, so the core takes the next item while the receiver stalls; a
// second result then waits for the first. After reset the core clears the
// fill memory, all GRID_DIM**3 buckets (4096 by default), one bucket per
// cycle, with in_ready low. Configuration writes are taken at any time and
// should only be made while the core idles.
module periodic_cell_list_occupancy_core #(
  parameter int GRID_DIM     = 16,
  parameter int BUCKET_DEPTH = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [pclo_pkg::CFGIDX_W-1:0] cfg_index,
  input  logic [pclo_pkg::VEC_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          operation,
  input  logic [pclo_pkg::FRAC_W-1:0]   frac_a,
  input  logic [pclo_pkg::FRAC_W-1:0]   frac_b,
  input  logic [pclo_pkg::FRAC_W-1:0]   frac_c,
  input  logic [pclo_pkg::COMP_W-1:0]   pos_x,
  input  logic [pclo_pkg::COMP_W-1:0]   pos_y,
  input  logic [pclo_pkg::COMP_W-1:0]   pos_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          occupied,
  output logic                          status
);
  import pclo_pkg::*;

  localparam int BUCKETS = GRID_DIM ** 3;
  localparam int GW      = $clog2(GRID_DIM);
  localparam int DW      = $clog2(GRID_DIM + 1);
  localparam int BW      = $clog2(BUCKETS);
  localparam int FW      = $clog2(BUCKET_DEPTH + 1);
  localparam int PW      = $clog2(BUCKETS * BUCKET_DEPTH);

  // Configuration registers.
  logic [VEC_W-1:0]    vec_a, vec_b, vec_c;
  logic [RAD_W-1:0]    radius;
  logic [DIVREG_W-1:0] div_a, div_b, div_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vec_a  <= '0;
      vec_b  <= '0;
      vec_c  <= '0;
      radius <= '0;
      div_a  <= DIVREG_W'(1);
      div_b  <= DIVREG_W'(1);
      div_c  <= DIVREG_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_VEC_A:  vec_a  <= cfg_data;
        REG_VEC_B:  vec_b  <= cfg_data;
        REG_VEC_C:  vec_c  <= cfg_data;
        REG_RADIUS: radius <= cfg_data[RAD_W-1:0];
        REG_DIV_A:  div_a  <= cfg_data[DIVREG_W-1:0];
        REG_DIV_B:  div_b  <= cfg_data[DIVREG_W-1:0];
        REG_DIV_C:  div_c  <= cfg_data[DIVREG_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective division counts: zero acts as one, clamp at the grid size.
  function automatic logic [DW-1:0] eff_div(input logic [DIVREG_W-1:0] v);
    logic [DW-1:0] r;
    if (v == '0) begin
      r = DW'(1);
    end else if (int'(v) > GRID_DIM) begin
      r = DW'(GRID_DIM);
    end else begin
      r = DW'(v);
    end
    return r;
  endfunction

  // Bucket along one axis from the wrapped fraction.
  function automatic logic [GW-1:0] axis_bucket(input logic [WRAP_W-1:0] w,
                                                input logic [DW-1:0] d);
    logic [WRAP_W+DW-1:0] prod;
    prod = (WRAP_W+DW)'(w) * (WRAP_W+DW)'(d);
    return GW'(prod >> WRAP_W);
  endfunction

  // Neighbor bucket with wrap-around.
  function automatic logic [GW-1:0] wrap_nb(input logic [GW-1:0] h,
                                            input logic [DW-1:0] d,
                                            input logic [1:0] o);
    logic [GW-1:0] r;
    case (o)
      OFS_NEG: r = (h == '0) ? GW'(d - DW'(1)) : h - GW'(1);
      OFS_POS: r = (DW'(h) + DW'(1) == d) ? '0 : h + GW'(1);
      default: r = h;
    endcase
    return r;
  endfunction

  logic [DW-1:0] da, db, dc;
  assign da = eff_div(div_a);
  assign db = eff_div(div_b);
  assign dc = eff_div(div_c);

  state_t state, state_next;

  // Item and working registers.
  logic               op;
  logic [WRAP_W-1:0]  wa, wb, wc;
  logic [COMP_W-1:0]  px, py, pz;
  logic [GW-1:0]      ha, hb, hc;
  logic [GW-1:0]      ca, cb, cc;
  logic [BW-1:0]      part_idx, bidx;
  logic [R2_W-1:0]    r2;
  ofs_sel_t           nb, img;
  logic [FW-1:0]      slot, fill_cnt;
  diff_t              diff;
  logic               res_occ, res_stat;
  logic [BW-1:0]      clr_addr;
  logic               clr_last;

  // Memory ports.
  logic               fill_we, fill_re;
  logic [BW-1:0]      fill_waddr;
  logic [FW-1:0]      fill_wdata, fill_q;
  logic               pt_we, pt_re;
  logic [PW-1:0]      pt_waddr, pt_raddr;
  logic [VEC_W-1:0]   pt_q;
  logic               hit;
  logic               out_load;

  assign clr_last = (clr_addr == BW'(BUCKETS - 1));

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_last) state_next = ST_IDLE;
      ST_IDLE:  if (in_valid) state_next = ST_HASH;
      ST_HASH:  state_next = (op == OP_QUERY) ? ST_NB : ST_IDX1;
      ST_NB:    state_next = ST_IDX1;
      ST_IDX1:  state_next = ST_IDX2;
      ST_IDX2:  state_next = ST_FRD;
      ST_FRD:   state_next = ST_FUSE;
      ST_FUSE: begin
        if (op == OP_INSERT) begin
          state_next = ST_DONE;
        end else if (fill_q != '0) begin
          state_next = ST_PRD;
        end else begin
          state_next = ofs_last(nb) ? ST_DONE : ST_NB;
        end
      end
      ST_PRD:   state_next = ST_PUSE;
      ST_PUSE:  state_next = ST_IMG;
      ST_IMG:   state_next = ST_SQ;
      ST_SQ:    state_next = ST_CMP;
      ST_CMP: begin
        if (hit) begin
          state_next = ST_DONE;
        end else if (!ofs_last(img)) begin
          state_next = ST_IMG;
        end else if (slot + FW'(1) < fill_cnt) begin
          state_next = ST_PRD;
        end else begin
          state_next = ofs_last(nb) ? ST_DONE : ST_NB;
        end
      end
      ST_DONE:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ready   = 1'b0;
    fill_re    = 1'b0;
    fill_we    = 1'b0;
    fill_waddr = bidx;
    fill_wdata = fill_q + FW'(1);
    pt_re      = 1'b0;
    pt_we      = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_CLEAR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_addr;
        fill_wdata = '0;
      end
      ST_IDLE: in_ready = 1'b1;
      ST_FRD:  fill_re  = 1'b1;
      ST_FUSE: begin
        if (op == OP_INSERT && int'(fill_q) < BUCKET_DEPTH) begin
          fill_we = 1'b1;
          pt_we   = 1'b1;
        end
      end
      ST_PRD:  pt_re    = 1'b1;
      ST_DONE: out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  assign pt_waddr = PW'(bidx) * PW'(BUCKET_DEPTH) + PW'(fill_q);
  assign pt_raddr = PW'(bidx) * PW'(BUCKET_DEPTH) + PW'(slot);

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + BW'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        op <= operation;
        wa <= frac_a[WRAP_W-1:0];
        wb <= frac_b[WRAP_W-1:0];
        wc <= frac_c[WRAP_W-1:0];
        px <= pos_x;
        py <= pos_y;
        pz <= pos_z;
      end
      ST_HASH: begin
        ha       <= axis_bucket(wa, da);
        hb       <= axis_bucket(wb, db);
        hc       <= axis_bucket(wc, dc);
        ca       <= axis_bucket(wa, da);
        cb       <= axis_bucket(wb, db);
        cc       <= axis_bucket(wc, dc);
        r2       <= R2_W'(radius) * R2_W'(radius);
        nb       <= '{ia: OFS_NEG, ib: OFS_NEG, ic: OFS_NEG};
        res_occ  <= 1'b0;
        res_stat <= STAT_OK;
      end
      ST_NB: begin
        ca <= wrap_nb(ha, da, nb.ia);
        cb <= wrap_nb(hb, db, nb.ib);
        cc <= wrap_nb(hc, dc, nb.ic);
      end
      ST_IDX1: part_idx <= BW'(ca) * BW'(db) + BW'(cb);
      ST_IDX2: bidx     <= part_idx * BW'(dc) + BW'(cc);
      ST_FUSE: begin
        fill_cnt <= fill_q;
        slot     <= '0;
        if (op == OP_INSERT && int'(fill_q) >= BUCKET_DEPTH) begin
          res_stat <= STAT_DROPPED;
        end
        if (op == OP_QUERY && fill_q == '0) begin
          nb <= ofs_next(nb);
        end
      end
      ST_PUSE: begin
        diff.x <= DIFF_W'(signed'(px)) - DIFF_W'(signed'(pt_q[COMP_W-1:0]));
        diff.y <= DIFF_W'(signed'(py)) - DIFF_W'(signed'(pt_q[2*COMP_W-1:COMP_W]));
        diff.z <= DIFF_W'(signed'(pz)) - DIFF_W'(signed'(pt_q[3*COMP_W-1:2*COMP_W]));
        img    <= '{ia: OFS_NEG, ib: OFS_NEG, ic: OFS_NEG};
      end
      ST_CMP: begin
        if (hit) begin
          res_occ <= 1'b1;
        end else if (!ofs_last(img)) begin
          img <= ofs_next(img);
        end else if (slot + FW'(1) < fill_cnt) begin
          slot <= slot + FW'(1);
        end else begin
          nb <= ofs_next(nb);
        end
      end
      default: ;
    endcase
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      occupied <= res_occ;
      status   <= res_stat;
    end
  end

  pclo_fill_ram #(
    .ADDR_W (BW),
    .DATA_W (FW)
  ) u_fill (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .re    (fill_re),
    .raddr (bidx),
    .rdata (fill_q)
  );

  pclo_point_ram #(
    .ADDR_W (PW)
  ) u_points (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata ({pz, py, px}),
    .re    (pt_re),
    .raddr (pt_raddr),
    .rdata (pt_q)
  );

  pclo_dist u_dist (
    .clk   (clk),
    .vec_a (vec_a),
    .vec_b (vec_b),
    .vec_c (vec_c),
    .diff  (diff),
    .sel   (img),
    .r2    (r2),
    .hit   (hit)
  );

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import pclo_pkg::*;

  localparam int GRID_DIM     = 16;
  localparam int BUCKET_DEPTH = 8;
  localparam int BUCKETS      = GRID_DIM * GRID_DIM * GRID_DIM;
  localparam int HOLD_CYCLES  = 3000;
  localparam int STALL_LIMIT  = 100000;

  // Register index that the core does not decode.
  localparam logic [CFGIDX_W-1:0] REG_NONE = 3'd7;

  typedef struct {
    logic op;
    logic [FRAC_W-1:0] fa, fb, fc;
    logic [COMP_W-1:0] px, py, pz;
  } point_op_t;

  typedef struct {
    logic occ;
    logic st;
  } answer_t;

  logic clk, rst;
  logic cfg_write;
  logic [CFGIDX_W-1:0] cfg_index;
  logic [VEC_W-1:0] cfg_data;
  logic in_valid, in_ready;
  logic operation;
  logic [FRAC_W-1:0] frac_a, frac_b, frac_c;
  logic [COMP_W-1:0] pos_x, pos_y, pos_z;
  logic out_valid, out_ready, occupied, status;

  periodic_cell_list_occupancy_core DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
    .frac_a(frac_a), .frac_b(frac_b), .frac_c(frac_c),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .occupied(occupied), .status(status)
  );

  // Shadow copy of the grid and the registers.
  logic [VEC_W-1:0] vec_a, vec_b, vec_c;
  logic [RAD_W-1:0] radius;
  logic [DIVREG_W-1:0] div_a, div_b, div_c;
  int bucket_count[BUCKETS];
  longint stored_pos[BUCKETS * BUCKET_DEPTH][3];

  point_op_t point_ops[$];
  point_op_t placed[$];
  answer_t pending_answers[$];
  int in_flight;
  int errors;
  int send_gap, recv_gap, hold_left;
  bit hold_req, hold_done, run_done;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int eff_div(input logic [DIVREG_W-1:0] v);
    if (v == 0) return 1;
    if (v > GRID_DIM) return GRID_DIM;
    return int'(v);
  endfunction

  function automatic longint vec_comp(input logic [VEC_W-1:0] v, input int n);
    logic signed [COMP_W-1:0] c;
    c = v[COMP_W*n +: COMP_W];
    return longint'(c);
  endfunction

  function automatic logic [VEC_W-1:0] pack_vec(input int x, input int y, input int z);
    return {COMP_W'(z), COMP_W'(y), COMP_W'(x)};
  endfunction

  // Works out the answer to one word and updates the shadow grid.
  function automatic answer_t occupancy_answer(input point_op_t w);
    answer_t r;
    int da, db, dc, ha, hb, hc, b, ia, ib, ic, m, s, fill;
    longint p[3], img[27][3], d[3], r2, x, y, z;
    r.occ = 1'b0;
    r.st = STAT_OK;
    da = eff_div(div_a);
    db = eff_div(div_b);
    dc = eff_div(div_c);
    ha = (int'(w.fa[WRAP_W-1:0]) * da) >>> 16;
    hb = (int'(w.fb[WRAP_W-1:0]) * db) >>> 16;
    hc = (int'(w.fc[WRAP_W-1:0]) * dc) >>> 16;
    p[0] = longint'($signed(w.px));
    p[1] = longint'($signed(w.py));
    p[2] = longint'($signed(w.pz));
    if (w.op == OP_INSERT) begin
      b = (ha * db + hb) * dc + hc;
      if (bucket_count[b] >= BUCKET_DEPTH) begin
        r.st = STAT_DROPPED;
      end else begin
        for (int c = 0; c < 3; c++) stored_pos[b * BUCKET_DEPTH + bucket_count[b]][c] = p[c];
        bucket_count[b]++;
      end
      return r;
    end
    r2 = longint'(radius) * longint'(radius);
    m = 0;
    for (int i = -1; i <= 1; i++)
      for (int j = -1; j <= 1; j++)
        for (int k = -1; k <= 1; k++) begin
          for (int c = 0; c < 3; c++)
            img[m][c] = vec_comp(vec_a, c) * i + vec_comp(vec_b, c) * j
                      + vec_comp(vec_c, c) * k;
          m++;
        end
    // Neighbor buckets with wrap-around, each point against all images.
    for (int di = -1; di <= 1; di++)
      for (int dj = -1; dj <= 1; dj++)
        for (int dk = -1; dk <= 1; dk++) begin
          ia = (ha + da + di) % da;
          ib = (hb + db + dj) % db;
          ic = (hc + dc + dk) % dc;
          b = (ia * db + ib) * dc + ic;
          fill = bucket_count[b];
          for (s = 0; s < fill && !r.occ; s++) begin
            for (int c = 0; c < 3; c++) d[c] = p[c] - stored_pos[b * BUCKET_DEPTH + s][c];
            for (int n = 0; n < 27; n++) begin
              x = d[0] - img[n][0];
              y = d[1] - img[n][1];
              z = d[2] - img[n][2];
              if (x * x + y * y + z * z < r2) r.occ = 1'b1;
            end
          end
        end
    return r;
  endfunction

  function automatic point_op_t mk(input logic op, input logic [FRAC_W-1:0] fa,
      input logic [FRAC_W-1:0] fb, input logic [FRAC_W-1:0] fc, input int px,
      input int py, input int pz);
    point_op_t w;
    w.op = op;
    w.fa = fa;
    w.fb = fb;
    w.fc = fc;
    w.px = COMP_W'(px);
    w.py = COMP_W'(py);
    w.pz = COMP_W'(pz);
    return w;
  endfunction

  // Fully random word of the given operation.
  function automatic point_op_t mk_random(input logic op);
    return mk(op, FRAC_W'($urandom), FRAC_W'($urandom), FRAC_W'($urandom),
              $urandom, $urandom, $urandom);
  endfunction

  // Mostly short gaps, a few long ones, and plenty of back-to-back words.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Random word: fresh inserts, clustered inserts, queries near stored points.
  function automatic point_op_t random_op();
    point_op_t w, base;
    int r, dl, sel;
    r = $urandom_range(0, 99);
    dl = (radius > 4096) ? 4096 : int'(radius) + 2;
    w = mk_random(OP_INSERT);
    if (r >= 40 && placed.size() > 0) begin
      base = placed[$urandom_range(0, placed.size() - 1)];
      w = base;
      w.px = base.px + COMP_W'($urandom_range(0, 2 * dl) - dl);
      w.py = base.py + COMP_W'($urandom_range(0, 2 * dl) - dl);
      w.pz = base.pz + COMP_W'($urandom_range(0, 2 * dl) - dl);
      w.op = (r < 55) ? OP_INSERT : OP_QUERY;
      sel = $urandom_range(0, 3);
      if (w.op == OP_QUERY && sel == 0) begin
        w.px = w.px + vec_a[COMP_W-1:0];
        w.py = w.py + vec_a[2*COMP_W-1:COMP_W];
        w.pz = w.pz + vec_a[3*COMP_W-1:2*COMP_W];
      end else if (w.op == OP_QUERY && sel == 1) begin
        w.px = w.px - vec_c[COMP_W-1:0];
        w.py = w.py - vec_c[2*COMP_W-1:COMP_W];
        w.pz = w.pz - vec_c[3*COMP_W-1:2*COMP_W];
      end
    end else if (r >= 85) begin
      w.op = OP_QUERY;
    end
    return w;
  endfunction

  task automatic write_reg(input logic [CFGIDX_W-1:0] idx, input logic [VEC_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_VEC_A:  vec_a = val;
      REG_VEC_B:  vec_b = val;
      REG_VEC_C:  vec_c = val;
      REG_RADIUS: radius = val[RAD_W-1:0];
      REG_DIV_A:  div_a = val[DIVREG_W-1:0];
      REG_DIV_B:  div_b = val[DIVREG_W-1:0];
      REG_DIV_C:  div_c = val[DIVREG_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic setup(input logic [VEC_W-1:0] va, input logic [VEC_W-1:0] vb,
      input logic [VEC_W-1:0] vc, input int rad, input int da, input int db, input int dc);
    write_reg(REG_VEC_A, va);
    write_reg(REG_VEC_B, vb);
    write_reg(REG_VEC_C, vc);
    write_reg(REG_RADIUS, VEC_W'(rad));
    write_reg(REG_DIV_A, VEC_W'(da));
    write_reg(REG_DIV_B, VEC_W'(db));
    write_reg(REG_DIV_C, VEC_W'(dc));
  endtask

  task automatic drain();
    while (point_ops.size() != 0 || in_flight != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Appends one word to the pending queue of the sender.
  task automatic queue_op(input point_op_t w);
    point_ops = {point_ops, w};
  endtask

  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) queue_op(random_op());
  endtask

  // Sender: one word on the bus at a time, random gaps between words.
  always @(posedge clk) begin
    point_op_t w;
    answer_t a;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        w = mk(operation, frac_a, frac_b, frac_c, pos_x, pos_y, pos_z);
        a = occupancy_answer(w);
        pending_answers = {pending_answers, a};
        if (w.op == OP_INSERT && a.st == STAT_OK) begin
          placed = {placed, w};
          if (placed.size() > 48) void'(placed.pop_front());
        end
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (point_ops.size() > 0) begin
          w = point_ops.pop_front();
          in_flight++;
          in_valid <= 1'b1;
          operation <= w.op;
          frac_a <= w.fa;
          frac_b <= w.fb;
          frac_c <= w.fc;
          pos_x <= w.px;
          pos_y <= w.py;
          pos_z <= w.pz;
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result word against the oldest prediction.
  always @(posedge clk) begin
    answer_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_answers.size() == 0) begin
          $display("%0t: unexpected result occupied=%0b status=%0b", $time, occupied, status);
          errors++;
        end else begin
          e = pending_answers.pop_front();
          in_flight--;
          if (occupied !== e.occ) begin
            $display("%0t: occupied expected %0b actual %0b", $time, e.occ, occupied);
            errors++;
          end
          if (status !== e.st) begin
            $display("%0t: status expected %0b actual %0b", $time, e.st, status);
            errors++;
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  // Watchdog on cycles with no word moving on either side.
  always @(posedge clk) begin
    if (rst || run_done || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL periodic_cell_list_occupancy_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    operation = OP_INSERT;
    frac_a = '0;
    frac_b = '0;
    frac_c = '0;
    pos_x = '0;
    pos_y = '0;
    pos_z = '0;
    out_ready = 1'b0;
    errors = 0;
    in_flight = 0;
    send_gap = 0;
    recv_gap = 0;
    hold_left = 0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    run_done = 1'b0;
    vec_a = '0;
    vec_b = '0;
    vec_c = '0;
    radius = '0;
    div_a = 5'd1;
    div_b = 5'd1;
    div_c = 5'd1;
    foreach (bucket_count[i]) bucket_count[i] = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: one bucket, zero radius. The ninth insert overflows.
    queue_op(mk(OP_INSERT, '0, '0, '0, 0, 0, 0));
    queue_op(mk(OP_INSERT, 24'h7FFFFF, 24'h800000, 24'hFFFFFF,
                1048575, -1048576, -1));
    queue_op(mk(OP_INSERT, 24'h800000, 24'h7FFFFF, 24'h00FFFF,
                -1048576, 1048575, 0));
    for (int i = 0; i < 6; i++)
      queue_op(mk_random(OP_INSERT));
    queue_op(mk(OP_QUERY, '0, '0, '0, 0, 0, 0));
    queue_op(mk(OP_QUERY, 24'hFFFFFF, 24'h000001, 24'h7F0000,
                1048575, 1048575, 1048575));
    drain();

    // Cubic box, full grid; radius boundary, image and wrap cases.
    setup(pack_vec(40000, 0, 0), pack_vec(0, 40000, 0), pack_vec(0, 0, 40000),
          2000, 16, 16, 16);
    write_reg(REG_NONE, {VEC_W{1'b1}});
    queue_op(mk(OP_INSERT, 24'h008000, 24'h008000, 24'h008000, 100, 100, 100));
    queue_op(mk(OP_QUERY, 24'h008000, 24'h008000, 24'h008000, 2099, 100, 100));
    queue_op(mk(OP_QUERY, 24'h008000, 24'h008000, 24'h008000, 2100, 100, 100));
    queue_op(mk(OP_QUERY, 24'h7F8000, 24'h018000, 24'hFF8000, 40100, 100, 100));
    queue_op(mk(OP_INSERT, 24'h000000, 24'h000000, 24'h000000, -5000, 7000, 9000));
    queue_op(mk(OP_QUERY, 24'h00FFFF, 24'h00FFFF, 24'h00FFFF, -5000, 7000, 9000));
    queue_op(mk(OP_QUERY, 24'h00FFFF, 24'h000000, 24'h000000, 35000, 7000, -31000));
    queue_op(mk(OP_QUERY, 24'h004000, 24'h00C000, 24'h002000, 300000, 0, 0));
    drain();
    push_random(350);
    drain();

    // Divisions of zero and above range, all-ones vectors, maximum radius.
    setup({VEC_W{1'b1}}, {VEC_W{1'b1}}, {VEC_W{1'b1}}, 1048575, 0, 31, 2);
    push_random(30);
    drain();

    // Random box and grid.
    setup(pack_vec($urandom, $urandom, $urandom), pack_vec($urandom, $urandom, $urandom),
          pack_vec($urandom, $urandom, $urandom), $urandom_range(500, 50000),
          $urandom_range(3, 16), $urandom_range(3, 16), $urandom_range(3, 16));
    push_random(400);
    drain();

    // Small radius, odd grid; the receiver holds off for a long stretch.
    setup(pack_vec($urandom_range(0, 60000), 0, $urandom), pack_vec($urandom, 50000, 0),
          pack_vec(0, $urandom, -60000), 1, 17, 16, 5);
    hold_req = 1'b1;
    push_random(400);
    drain();

    run_done = 1'b1;
    if (errors == 0) begin
      $display("PASS periodic_cell_list_occupancy_core");
    end else begin
      $display("FAIL periodic_cell_list_occupancy_core");
    end
    $finish;
  end

endmodule
